// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the translator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define GTR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define GTR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/gtr_pkg.sv =====
// Shared types and constants of the glob to regex translator.
package gtr_pkg;

  localparam int unsigned MaxBytes = 3;

  localparam logic [7:0] ChDollar = 8'h24;

  // One queued transaction: the regex bytes produced by one glob item.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [1:0]               n_m1;      // number of bytes minus one
    logic                     has_last;  // last byte of the item is among the bytes
    logic                     is_end;    // item was the end marker
  } entry_t;

endpackage

// ===== hdl/gtr_front.sv =====
// Front end: accepts glob items, tracks scan state and builds byte transactions.
module gtr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              mode_i,
  input  logic [7:0]        ch_i,
  output logic              q_push_o,
  output gtr_pkg::entry_t   q_data_o
);

  typedef enum logic [2:0] {
    ScOut     = 3'd0,
    ScOutEsc  = 3'd1,
    ScClsOpen = 3'd2,
    ScClsNeg  = 3'd3,
    ScClsBody = 3'd4,
    ScClsEsc  = 3'd5
  } scan_e;

  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChQuest  = 8'h3F;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChCaret  = 8'h5E;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] ChLBrack = 8'h5B;
  localparam logic [7:0] ChRBrack = 8'h5D;
  localparam logic [7:0] ChBslash = 8'h5C;

  scan_e       scan_q, scan_d;
  logic        started_q, started_d;
  logic [2:0][7:0] tok;
  logic [1:0]  tok_len;
  logic [3:0][7:0] seq;
  logic [2:0]  seq_len;
  logic        live;

  assign live = accept_i && (mode_i || (ch_i != 8'h00));

  always_comb begin
    tok       = '0;
    tok_len   = 2'd0;
    scan_d    = scan_q;
    started_d = started_q;
    if (mode_i) begin
      scan_d    = ScOut;
      started_d = 1'b0;
      case (scan_q)
        ScOutEsc: begin
          tok = {gtr_pkg::ChDollar, ChBslash, ChBslash};
          tok_len = 2'd3;
        end
        ScClsOpen, ScClsNeg, ScClsBody: begin
          tok = {8'h00, gtr_pkg::ChDollar, ChRBrack};
          tok_len = 2'd2;
        end
        ScClsEsc: begin
          tok = {gtr_pkg::ChDollar, ChRBrack, ChBslash};
          tok_len = 2'd3;
        end
        default: begin
          tok = {16'h0000, gtr_pkg::ChDollar};
          tok_len = 2'd1;
        end
      endcase
    end else begin
      started_d = 1'b1;
      case (scan_q)
        ScOutEsc: begin
          tok = {8'h00, ch_i, ChBslash};
          tok_len = 2'd2;
          scan_d = ScOut;
        end
        ScClsOpen, ScClsNeg: begin
          if (scan_q == ScClsOpen && (ch_i inside {ChBang, ChCaret})) begin
            tok = {16'h0000, ChCaret};
            tok_len = 2'd1;
            scan_d = ScClsNeg;
          end else if (ch_i == ChRBrack) begin
            tok = {8'h00, ChRBrack, ChBslash};
            tok_len = 2'd2;
            scan_d = ScClsBody;
          end else if (ch_i == ChBslash) begin
            scan_d = ScClsEsc;
          end else begin
            tok = {16'h0000, ch_i};
            tok_len = 2'd1;
            scan_d = ScClsBody;
          end
        end
        ScClsBody: begin
          if (ch_i == ChRBrack) begin
            tok = {16'h0000, ChRBrack};
            tok_len = 2'd1;
            scan_d = ScOut;
          end else if (ch_i == ChBslash) begin
            scan_d = ScClsEsc;
          end else begin
            tok = {16'h0000, ch_i};
            tok_len = 2'd1;
          end
        end
        ScClsEsc: begin
          tok = {8'h00, ch_i, ChBslash};
          tok_len = 2'd2;
          scan_d = ScClsBody;
        end
        default: begin
          scan_d = ScOut;
          if (ch_i == ChStar) begin
            tok = {8'h00, ChStar, ChDot};
            tok_len = 2'd2;
          end else if (ch_i == ChQuest) begin
            tok = {16'h0000, ChDot};
            tok_len = 2'd1;
          end else if (ch_i == ChLBrack) begin
            tok = {16'h0000, ChLBrack};
            tok_len = 2'd1;
            scan_d = ScClsOpen;
          end else if (ch_i == ChBslash) begin
            scan_d = ScOutEsc;
          end else if (ch_i inside {8'h2E, 8'h5E, 8'h24, 8'h2B, 8'h28, 8'h29,
                                    8'h7B, 8'h7D, 8'h7C}) begin
            tok = {8'h00, ch_i, ChBslash};
            tok_len = 2'd2;
          end else begin
            tok = {16'h0000, ch_i};
            tok_len = 2'd1;
          end
        end
      endcase
    end
  end

  // Caret goes in front of the first item of a glob.
  always_comb begin
    if (!started_q) begin
      seq     = {tok, ChCaret};
      seq_len = {1'b0, tok_len} + 3'd1;
    end else begin
      seq     = {8'h00, tok};
      seq_len = {1'b0, tok_len};
    end
  end

  always_comb begin
    q_data_o.bytes  = seq[2:0];
    q_data_o.is_end = mode_i;
    if (seq_len > 3'd3) begin
      q_data_o.n_m1     = 2'd2;
      q_data_o.has_last = 1'b0;
    end else begin
      q_data_o.n_m1     = 2'(seq_len - 3'd1);
      q_data_o.has_last = 1'b1;
    end
  end

  assign q_push_o = live && (seq_len != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q    <= ScOut;
      started_q <= 1'b0;
    end else if (live) begin
      scan_q    <= scan_d;
      started_q <= started_d;
    end
  end

endmodule

// ===== hdl/gtr_queue.sv =====
// Small register queue of byte transactions between front and back.
module gtr_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gtr_pkg::entry_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output gtr_pkg::entry_t rdata_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  gtr_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            wr, rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign wr      = push_i && !full_o;
  assign rd      = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (rd) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (wr && !rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd && !wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hdl/gtr_back.sv =====
// Back end: walks queued transactions one byte at a time into the output register.
module gtr_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  gtr_pkg::entry_t q_data_i,
  output logic            q_pop_o,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      out_char_o,
  output logic            last_o,
  output logic            pattern_end_o
);

  logic [1:0] idx_q;
  logic       out_valid_q;
  logic [7:0] char_q;
  logic       last_q, pend_q;
  logic       emit, final_byte, byte_last;

  assign emit       = !q_empty_i && (!out_valid_q || pop);
  assign final_byte = (idx_q == q_data_i.n_m1);
  assign byte_last  = final_byte && q_data_i.has_last;
  assign q_pop_o    = emit && final_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        idx_q       <= final_byte ? 2'd0 : idx_q + 2'd1;
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      char_q <= q_data_i.bytes[idx_q];
      last_q <= byte_last;
      pend_q <= byte_last && q_data_i.is_end;
    end
  end

  assign empty         = !out_valid_q;
  assign out_char_o    = char_q;
  assign last_o        = last_q;
  assign pattern_end_o = pend_q;

endmodule

// ===== hdl/glob_to_regex_translator.sv =====
// Top level of the glob to regex translator.
//
// Input channel: a queue write port. Drive mode_i/ch_i and raise push; the
// transaction is taken on a clock edge where push is high and full is low.
// mode_i = 0 carries one glob byte in ch_i, mode_i = 1 closes the glob.
// A zero byte is taken and dropped. Output channel: a queue read port. While
// empty is low, out_char_o/last_o/pattern_end_o show the oldest regex byte,
// which leaves on an edge where pop is high.
// An item's first byte goes through the transaction queue, then the output register.
// Throughput: one regex byte per cycle while the receiver keeps popping, set by the
// single output register; an item yields 0 to 3 regex bytes, two for a star or an
// escaped character. The front takes one item per cycle while the
// transaction queue (QueueDepth entries) has room.
// Reset: queue and output empty, scan state outside any class, caret pending.
// When the receiver stalls the output byte holds, the queue fills, and full
// rises; nothing is dropped.
`include "assert_macros.svh"

module glob_to_regex_translator #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       mode_i,
  input  logic [7:0] ch_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_o,
  output logic       last_o,
  output logic       pattern_end_o
);

  logic            accept;
  logic            q_push, q_pop, q_full, q_empty;
  gtr_pkg::entry_t q_wdata, q_rdata;

  assign full   = q_full;
  assign accept = push && !q_full;

  gtr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .mode_i   (mode_i),
    .ch_i     (ch_i),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  gtr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  gtr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .empty         (empty),
    .pop           (pop),
    .out_char_o    (out_char_o),
    .last_o        (last_o),
    .pattern_end_o (pattern_end_o)
  );

  `GTR_ASSERT_IMP(a_pend_is_last, !empty && pattern_end_o, last_o,
                  "pattern end byte not marked last")
  `GTR_ASSERT_IMP(a_pend_dollar, !empty && pattern_end_o, out_char_o == gtr_pkg::ChDollar,
                  "pattern end byte is not a dollar sign")
  `GTR_ASSERT_IMP(a_no_nul, !empty, out_char_o != 8'h00,
                  "zero byte on output")
  `GTR_ASSERT_IMP(a_pop_nonempty, q_pop, !q_empty,
                  "back end pops an empty queue")
  `GTR_ASSERT_NXT(a_hold_on_stall, !empty && !pop, !empty && $stable(out_char_o),
                  "output byte changed while stalled")

endmodule
